// ===== src/paa_pkg.sv =====
`default_nettype none
package paa_pkg;
  localparam int unsigned MaxAttractors = 4;
  localparam int unsigned NumAttRegs = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 60;
  localparam logic [CfgIdxW-1:0] RegNumAtt = 3'd0;
  localparam int unsigned NumW = 42;
  localparam int unsigned DenW = 42;
  localparam int unsigned QuoW = 64;
  localparam int unsigned MagW = 58;

  typedef struct packed {
    logic        start;
    logic        neg;
    logic [MagW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic signed [QuoW-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== src/paa_div.sv =====
`default_nettype none
module paa_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire paa_pkg::div_req_t req,
  output paa_pkg::div_rsp_t      rsp
);
  import paa_pkg::*;

  localparam int unsigned CntW = $clog2(MagW + 1);

  logic [MagW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r;
  logic            neg_r;
  logic            busy_r, busy_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic [DenW:0]   trial;
  logic [DenW+1:0] diff;

  always_comb begin
    trial = {rem_r[DenW-1:0], q_r[MagW-1]};
    diff = {1'b0, trial} - {2'b0, den_r};
    q_nxt = q_r;
    rem_nxt = rem_r;
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      busy_nxt = 1'b1;
      cnt_nxt = CntW'(MagW);
    end else if (busy_r) begin
      if (!diff[DenW+1]) begin
        rem_nxt = diff[DenW:0];
        q_nxt = {q_r[MagW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[MagW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      den_r <= req.den;
      neg_r <= req.neg;
    end
  end

  always_comb begin
    rsp.done = done_r;
    rsp.quo = neg_r ? -$signed({{(QuoW-MagW){1'b0}}, q_r})
                    : $signed({{(QuoW-MagW){1'b0}}, q_r});
  end
endmodule
`default_nettype wire

// ===== src/particle_attractor_accel_unit.sv =====
// Channel | Direction | Payload
// in_     | input     | pos_x, pos_y, acc_x, acc_y, is_last
// out_    | output    | new_acc_x, new_acc_y, last_out, saturated, on_attractor
// cfg_    | input     | register index and 60-bit write data
// Each attractor: form the offset, multiply for the squared distance and the numerator,
// and run two divisions (load, 58 restoring steps, result) on the shared bit-serial
// divider. An attractor at zero distance skips both divisions and sets on_attractor.
// out_valid is set from S_OFF after the last attractor; in_ready is low from acceptance
// until the cycle after the result is taken. Reset is synchronous and active low.
`default_nettype none
module particle_attractor_accel_unit #(
  parameter int unsigned MAX_ATTRACTORS = paa_pkg::MaxAttractors
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic signed [19:0] in_pos_x,
  input  wire logic signed [19:0] in_pos_y,
  input  wire logic signed [31:0] in_acc_x,
  input  wire logic signed [31:0] in_acc_y,
  input  wire logic in_is_last,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic signed [31:0] out_new_acc_x,
  output logic signed [31:0] out_new_acc_y,
  output logic      out_last_out,
  output logic      out_saturated,
  output logic      out_on_attractor,
  input  wire logic cfg_we,
  input  wire logic [paa_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [paa_pkg::CfgDataW-1:0] cfg_data
);
  import paa_pkg::*;

  localparam int unsigned NReg = (MAX_ATTRACTORS < NumAttRegs) ? MAX_ATTRACTORS : NumAttRegs;
  localparam int unsigned AW = (NReg > 1) ? $clog2(NReg) : 1;

  typedef enum logic [2:0] {S_IDLE, S_OFF, S_SQ, S_NUM, S_DIVX, S_DIVY, S_OUT} state_t;

  state_t state_r;
  logic [2:0] num_r;
  logic [CfgDataW-1:0] att_r [NReg];
  logic [2:0] j_r;
  logic signed [19:0] px_r, py_r;
  logic signed [31:0] ax_r, ay_r;
  logic last_r, sat_r, hit_r;
  logic signed [20:0] ox_r, oy_r;
  logic [41:0] d2_r;
  logic signed [40:0] sq_r;
  logic signed [41:0] prod_r;
  logic [1:0] ph_r;
  logic div_pend_r;
  logic [2:0] n_eff;
  logic [CfgDataW-1:0] cur;
  logic signed [19:0] st;
  div_req_t dreq;
  div_rsp_t drsp;
  logic signed [64:0] sum;
  logic signed [31:0] satv;
  logic sat_hit;

  assign n_eff = (num_r > 3'(NReg)) ? 3'(NReg) : num_r;
  assign cur = att_r[j_r[AW-1:0]];
  assign st = $signed(cur[59:40]);

  always_comb begin
    dreq.start = (state_r == S_DIVX || state_r == S_DIVY) && !div_pend_r;
    dreq.neg = prod_r[41];
    dreq.num = {prod_r[41] ? 42'(-prod_r) : 42'(prod_r), 16'b0};
    dreq.den = d2_r;
  end

  paa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    sum = (state_r == S_DIVX) ? 65'(ax_r) + 65'(drsp.quo) : 65'(ay_r) + 65'(drsp.quo);
    sat_hit = 1'b1;
    if (sum > 65'sd2147483647) satv = 32'sh7FFFFFFF;
    else if (sum < -65'sd2147483648) satv = 32'sh80000000;
    else begin
      satv = sum[31:0];
      sat_hit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= '0;
      for (int i = 0; i < NReg; i++) att_r[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == RegNumAtt) num_r <= cfg_data[2:0];
      else if ({1'b0, cfg_index} <= (CfgIdxW+1)'(NReg))
        att_r[AW'(cfg_index - 1'b1)] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
      div_pend_r <= 1'b0;
      j_r <= '0;
      ph_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            px_r <= in_pos_x;
            py_r <= in_pos_y;
            ax_r <= in_acc_x;
            ay_r <= in_acc_y;
            last_r <= in_is_last;
            sat_r <= 1'b0;
            hit_r <= 1'b0;
            j_r <= '0;
            state_r <= S_OFF;
          end
        end
        S_OFF: begin
          if (j_r >= n_eff) begin
            state_r <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            ox_r <= 21'($signed(cur[19:0])) - 21'(px_r);
            oy_r <= 21'($signed(cur[39:20])) - 21'(py_r);
            ph_r <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          ph_r <= ph_r + 1'b1;
          if (ph_r == 2'd0) sq_r <= ox_r * ox_r;
          else begin
            d2_r <= 42'(sq_r) + 42'(oy_r * oy_r);
            state_r <= S_NUM;
          end
        end
        S_NUM: begin
          if (d2_r == '0) begin
            hit_r <= 1'b1;
            j_r <= j_r + 1'b1;
            state_r <= S_OFF;
          end else begin
            prod_r <= ox_r * st;
            state_r <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (drsp.done) begin
            ax_r <= satv;
            sat_r <= sat_r | sat_hit;
            prod_r <= oy_r * st;
            div_pend_r <= 1'b0;
            state_r <= S_DIVY;
          end else begin
            div_pend_r <= 1'b1;
          end
        end
        S_DIVY: begin
          if (drsp.done) begin
            ay_r <= satv;
            sat_r <= sat_r | sat_hit;
            div_pend_r <= 1'b0;
            j_r <= j_r + 1'b1;
            state_r <= S_OFF;
          end else begin
            div_pend_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_new_acc_x = ax_r;
  assign out_new_acc_y = ay_r;
  assign out_last_out = last_r;
  assign out_saturated = sat_r;
  assign out_on_attractor = hit_r;
endmodule
`default_nettype wire

// ===== sim/particle_attractor_accel_unit_checker.sv =====
`timescale 1ns / 1ps
module particle_attractor_accel_unit_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire logic signed [19:0] in_pos_x,
  input  wire logic signed [19:0] in_pos_y,
  input  wire logic signed [31:0] in_acc_x,
  input  wire logic signed [31:0] in_acc_y,
  input  wire logic in_is_last,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  wire logic signed [31:0] out_new_acc_x,
  input  wire logic signed [31:0] out_new_acc_y,
  input  wire logic out_last_out,
  input  wire logic out_saturated,
  input  wire logic out_on_attractor,
  input  wire logic cfg_we,
  input  wire logic [paa_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [paa_pkg::CfgDataW-1:0] cfg_data,
  output int errors,
  output int pending
);
  import paa_pkg::*;

  typedef struct packed {
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic last;
    logic sat;
    logic hit;
  } accel_t;

  logic [2:0] att_count;
  logic [59:0] att_regs [MaxAttractors];
  accel_t accel_q[$];

  function automatic longint clamp_sum(longint a, longint b, ref logic sat);
    longint s;
    s = a + b;
    if (s > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (s < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return s;
  endfunction

  function automatic accel_t predict_accel(logic signed [19:0] px, logic signed [19:0] py,
                                           logic signed [31:0] ax, logic signed [31:0] ay,
                                           logic last);
    accel_t r;
    longint sx, sy, tx, ty, st, ox, oy, d2;
    int n;
    logic sat;
    logic hit;
    sat = 1'b0;
    hit = 1'b0;
    sx = ax;
    sy = ay;
    n = (att_count > MaxAttractors) ? MaxAttractors : att_count;
    for (int j = 0; j < n; j++) begin
      tx = longint'($signed(att_regs[j][19:0]));
      ty = longint'($signed(att_regs[j][39:20]));
      st = longint'($signed(att_regs[j][59:40]));
      ox = tx - px;
      oy = ty - py;
      d2 = ox * ox + oy * oy;
      if (d2 == 0) begin
        hit = 1'b1;
      end else begin
        sx = clamp_sum(sx, (ox * st * 65536) / d2, sat);
        sy = clamp_sum(sy, (oy * st * 65536) / d2, sat);
      end
    end
    r.acc_x = sx[31:0];
    r.acc_y = sy[31:0];
    r.last = last;
    r.sat = sat;
    r.hit = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    accel_t e;
    if (!rst_n) begin
      att_count <= '0;
      for (int i = 0; i < MaxAttractors; i++) att_regs[i] <= '0;
      accel_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegNumAtt) begin
          att_count <= cfg_data[2:0];
        end else if (cfg_index <= NumAttRegs && (cfg_index - 1) < MaxAttractors) begin
          att_regs[cfg_index-1] <= cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        accel_q.push_back(predict_accel(in_pos_x, in_pos_y, in_acc_x, in_acc_y, in_is_last));
      end
      if (out_valid && out_ready) begin
        if (accel_q.size() == 0) begin
          $display("%0t: unexpected transaction x=%h y=%h", $time, out_new_acc_x,
                   out_new_acc_y);
          errors <= errors + 1;
        end else begin
          e = accel_q.pop_front();
          if (e != {out_new_acc_x, out_new_acc_y, out_last_out, out_saturated,
                     out_on_attractor}) begin
            $display("%0t: mismatch expected x=%h y=%h l=%b s=%b h=%b actual x=%h y=%h l=%b s=%b h=%b",
                     $time, e.acc_x, e.acc_y, e.last, e.sat, e.hit, out_new_acc_x,
                     out_new_acc_y, out_last_out, out_saturated, out_on_attractor);
            errors <= errors + 1;
          end
        end
      end
      pending <= accel_q.size();
    end
  end
endmodule

// ===== sim/particle_attractor_accel_unit_tb.sv =====
`timescale 1ns / 1ps
module particle_attractor_accel_unit_tb;
  import paa_pkg::*;

  localparam int LimitCycles = 1500000;
  localparam logic [CfgIdxW-1:0] RegAtt0 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBeyond = 3'd5;
  localparam logic [CfgIdxW-1:0] RegUnknown = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [19:0] in_pos_x;
  logic signed [19:0] in_pos_y;
  logic signed [31:0] in_acc_x;
  logic signed [31:0] in_acc_y;
  logic in_is_last;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_new_acc_x;
  logic signed [31:0] out_new_acc_y;
  logic out_last_out;
  logic out_saturated;
  logic out_on_attractor;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int errors;
  int pending;
  int cycles;
  int send_idle;
  int recv_stall;
  logic signed [19:0] att_x [4];
  logic signed [19:0] att_y [4];

  particle_attractor_accel_unit u_top (.*);
  particle_attractor_accel_unit_checker u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LimitCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic send_particle(logic signed [19:0] px, logic signed [19:0] py,
                               logic signed [31:0] ax, logic signed [31:0] ay, logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_acc_x <= ax;
    in_acc_y <= ay;
    in_is_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_attractors(int n);
    logic signed [19:0] s;
    for (int k = 0; k < 4; k++) begin
      att_x[k] = 20'($urandom);
      att_y[k] = 20'($urandom);
      s = 20'($urandom);
      case ($urandom_range(3))
        0: s = 20'sh7FFFF;
        1: s = -20'sh80000;
        default: ;
      endcase
      write_reg(RegAtt0 + CfgIdxW'(k), {s, att_y[k], att_x[k]});
    end
    write_reg(RegNumAtt, CfgDataW'(n));
  endtask

  task automatic random_particle();
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    int k;
    px = 20'($urandom);
    py = 20'($urandom);
    ax = $urandom;
    ay = $urandom;
    k = $urandom_range(3);
    case ($urandom_range(7))
      0: begin
        px = att_x[k];
        py = att_y[k];
      end
      1: begin
        px = att_x[k] + $signed(20'($urandom_range(8))) - 20'sd4;
        py = att_y[k] + $signed(20'($urandom_range(8))) - 20'sd4;
      end
      2: begin
        ax = $urandom_range(1) ? 32'sh7FFFFF00 : 32'sh80000100;
      end
      default: ;
    endcase
    send_particle(px, py, ax, ay, 1'($urandom_range(1)));
  endtask

  initial begin
    rst_n = 1'b0;
    cycles = 0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_acc_x = '0;
    in_acc_y = '0;
    in_is_last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle = 0;
    recv_stall = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_particle(20'sh12345, -20'sh01000, 32'sh7FFFFFFF, -32'sh80000000, 1'b1);
    settle();
    write_reg(RegAtt0, {20'sh7FFFF, 20'sh00000, 20'sh00000});
    write_reg(RegAtt0 + 3'd1, {-20'sh80000, 20'sh7FFFF, -20'sh80000});
    write_reg(RegAtt0 + 3'd2, {20'sh00100, -20'sh80000, 20'sh7FFFF});
    write_reg(RegAtt0 + 3'd3, {20'sh7FFFF, 20'sh00010, 20'sh00010});
    write_reg(RegNumAtt, CfgDataW'(3'd7));
    send_particle(20'sh00000, 20'sh00000, 32'sh0, 32'sh0, 1'b0);
    send_particle(-20'sh80000, 20'sh7FFFF, 32'sh0, 32'sh0, 1'b1);
    send_particle(20'sh7FFFF, -20'sh80000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
    send_particle(20'sh7FFFF, -20'sh80000, -32'sh80000000, -32'sh80000000, 1'b1);
    send_particle(20'sh00011, 20'sh00010, 32'sh7FFFFFF0, -32'sh7FFFFFF0, 1'b0);
    send_particle(20'sh00010, 20'sh00010, 32'shFFFFFFFF, 32'sh1, 1'b1);
    send_particle(20'sh7FFFF, 20'sh7FFFF, 32'sh12345678, -32'sh1234567, 1'b0);
    send_particle(-20'sh1, -20'sh1, 32'sh0, 32'sh0, 1'b1);
    settle();
    write_reg(RegNumAtt, CfgDataW'(3'd5));
    write_reg(RegBeyond, {CfgDataW{1'b1}});
    write_reg(RegUnknown, {CfgDataW{1'b1}});
    send_particle(20'sh00010, 20'sh00010, 32'sh0, 32'sh0, 1'b0);
    send_particle(20'sh00100, -20'sh80000, 32'sh100, 32'sh100, 1'b1);
    settle();
    write_reg(RegNumAtt, CfgDataW'(3'd0));
    send_particle(20'sh00010, 20'sh00010, 32'sh55AA55AA, -32'sh2, 1'b1);
    settle();

    for (int ph = 0; ph < 15; ph++) begin
      case (ph % 5)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 48; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 48; end
        3: begin send_idle = 30; recv_stall = 30; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      random_attractors((ph % 5 == 4) ? $urandom_range(7) : 1 + $urandom_range(3));
      for (int i = 0; i < 50; i++) random_particle();
      settle();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
